FILE: sv/ckpd_pkg.sv
// ----------------------------------------------------------------------------
// ckpd_pkg
// Shared types and constants for the checksummed packet deframer.
// ----------------------------------------------------------------------------
package ckpd_pkg;

	localparam int DEFAULT_MAX_PAYLOAD = 1024;

	localparam logic [7:0]  START_A  = 8'hA0;
	localparam logic [7:0]  START_B  = 8'hA2;
	localparam logic [7:0]  END_A    = 8'hB0;
	localparam logic [7:0]  END_B    = 8'hB3;
	localparam logic [14:0] SUM_MASK = 15'h7FFF;

	typedef enum logic [3:0] {
		PH_HUNT0,
		PH_HUNT1,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_CK_LO,
		PH_CK_HI,
		PH_END0,
		PH_END1
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TYPE = 2'd0,
		KIND_DATA = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_START    = 3'd1,
		ST_BAD_LENGTH   = 3'd2,
		ST_BAD_CHECKSUM = 3'd3,
		ST_BAD_END      = 3'd4
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		status_t     status;
		logic [15:0] payload_length;
	} result_t;

endpackage

FILE: sv/checksummed_packet_deframer.sv
// ----------------------------------------------------------------------------
// checksummed_packet_deframer
// Cuts a received byte stream into length-prefixed frames with a 15-bit sum
// checksum, emitting type and data bytes and one status item per frame.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while in_stall is low, with no bubbles between bytes.
// Each byte is decoded by the frame state machine in the cycle it is
// accepted, and any result it causes is registered before it reaches the output.
// Results pass through an output register backed by a one-entry skid buffer,
// so input transfers continue while a result waits on a stalled output; the
// input stalls only once the skid buffer holds a result as well.
module checksummed_packet_deframer
	import ckpd_pkg::*;
#(
	parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  value,
	output logic [2:0]  status,
	output logic [15:0] payload_length
);

	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

	phase_t      phase_q, phase_d;
	logic [15:0] frame_length_q;
	logic [15:0] byte_count_q;
	logic [14:0] running_sum_q;
	logic [7:0]  checksum_low_byte_q;

	logic        in_accept;
	logic [15:0] length_rx;
	logic [15:0] count_next;
	logic [15:0] checksum_rx;
	logic        length_bad;

	logic        res_push;
	result_t     res;

	logic        out_valid_q;
	result_t     out_q;
	logic        skid_valid_q;
	result_t     skid_q;
	logic        out_free;

	assign in_stall    = skid_valid_q;
	assign in_accept   = in_valid && !in_stall;
	assign length_rx   = {rx_byte, frame_length_q[7:0]};
	assign count_next  = byte_count_q + 16'd1;
	assign checksum_rx = {rx_byte, checksum_low_byte_q};
	assign length_bad  = (length_rx == 16'd0) || (length_rx > MAX_LEN);

	always_comb begin
		phase_d = phase_q;
		if (in_accept) begin
			unique case (phase_q)
				PH_HUNT0: begin
					if (rx_byte == START_A) phase_d = PH_HUNT1;
				end
				PH_HUNT1: begin
					if (rx_byte == START_B) phase_d = PH_LEN_LO;
					else if (rx_byte == START_A) phase_d = PH_HUNT1;
					else phase_d = PH_HUNT0;
				end
				PH_LEN_LO: phase_d = PH_LEN_HI;
				PH_LEN_HI: phase_d = length_bad ? PH_HUNT0 : PH_PAYLOAD;
				PH_PAYLOAD: begin
					if (count_next >= frame_length_q) phase_d = PH_CK_LO;
				end
				PH_CK_LO: phase_d = PH_CK_HI;
				PH_CK_HI: begin
					phase_d = (checksum_rx != {1'b0, running_sum_q}) ? PH_HUNT0 : PH_END0;
				end
				PH_END0: phase_d = (rx_byte != END_A) ? PH_HUNT0 : PH_END1;
				PH_END1: phase_d = PH_HUNT0;
				default: phase_d = PH_HUNT0;
			endcase
		end
	end

	always_comb begin
		res_push = 1'b0;
		res      = '{kind: KIND_DONE, value: 8'd0, status: ST_OK, payload_length: 16'd0};
		if (in_accept) begin
			unique case (phase_q)
				PH_HUNT1: begin
					if (rx_byte != START_B) begin
						res_push   = 1'b1;
						res.status = ST_BAD_START;
					end
				end
				PH_LEN_HI: begin
					if (length_bad) begin
						res_push           = 1'b1;
						res.status         = ST_BAD_LENGTH;
						res.payload_length = length_rx;
					end
				end
				PH_PAYLOAD: begin
					res_push  = 1'b1;
					res.kind  = (byte_count_q == 16'd0) ? KIND_TYPE : KIND_DATA;
					res.value = rx_byte;
				end
				PH_CK_HI: begin
					if (checksum_rx != {1'b0, running_sum_q}) begin
						res_push           = 1'b1;
						res.status         = ST_BAD_CHECKSUM;
						res.payload_length = frame_length_q;
					end
				end
				PH_END0: begin
					if (rx_byte != END_A) begin
						res_push           = 1'b1;
						res.status         = ST_BAD_END;
						res.payload_length = frame_length_q;
					end
				end
				PH_END1: begin
					res_push           = 1'b1;
					res.status         = (rx_byte != END_B) ? ST_BAD_END : ST_OK;
					res.payload_length = frame_length_q;
				end
				default: res_push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q             <= PH_HUNT0;
			frame_length_q      <= 16'd0;
			byte_count_q        <= 16'd0;
			running_sum_q       <= 15'd0;
			checksum_low_byte_q <= 8'd0;
		end else begin
			phase_q <= phase_d;
			if (in_accept) begin
				unique case (phase_q)
					PH_LEN_LO: frame_length_q <= {8'd0, rx_byte};
					PH_LEN_HI: begin
						frame_length_q <= length_rx;
						if (!length_bad) begin
							byte_count_q  <= 16'd0;
							running_sum_q <= 15'd0;
						end
					end
					PH_PAYLOAD: begin
						running_sum_q <= (running_sum_q + {7'd0, rx_byte}) & SUM_MASK;
						byte_count_q  <= count_next;
					end
					PH_CK_LO: checksum_low_byte_q <= rx_byte;
					default: begin
					end
				endcase
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || res_push;
			skid_valid_q <= 1'b0;
		end else if (res_push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_push) begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign value          = out_q.value;
	assign status         = out_q.status;
	assign payload_length = out_q.payload_length;

endmodule

FILE: sim/tb_checksummed_packet_deframer.sv
// ----------------------------------------------------------------------------
// tb_checksummed_packet_deframer
// Self-checking testbench for the checksummed packet deframer. A short table
// of hand-picked bytes covers noise, bad start, bad length, bad checksum, bad
// end and a good frame. Random frames follow, mostly well formed and some
// broken on purpose, including one frame of the largest length. Every
// accepted byte is run through a behavioral frame decoder, and each output
// transfer is compared field by field with the oldest predicted result.
// Both sides insert random bubbles, and the sink holds off once for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_checksummed_packet_deframer;
	timeunit 1ns;
	timeprecision 1ps;
	import ckpd_pkg::*;

	localparam int MAX_LEN         = DEFAULT_MAX_PAYLOAD;
	localparam int N_DIRECTED      = 33;
	localparam int RANDOM_BYTES    = 1800;
	localparam int IDLE_PCT        = 9;
	localparam int HOLD_FIRST      = 200;
	localparam int HOLD_CYCLES     = 60;
	localparam int SINK_CALM_FIRST = 1300;
	localparam int SINK_CALM_LAST  = 1700;
	localparam int SRC_CALM_FIRST  = 900;
	localparam int SRC_CALM_LAST   = 1200;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct {
		logic [7:0] rx;
		bit         typed;
		result_t    res;
	} tx_step_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  kind;
	logic [7:0]  value;
	logic [2:0]  status;
	logic [15:0] payload_length;

	tx_step_t    directed [N_DIRECTED];
	tx_step_t    offered_steps [$];
	result_t     pending_results [$];
	int unsigned bytes_sent   = 0;
	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;

	phase_t      frame_phase = PH_HUNT0;
	logic [15:0] frame_len   = '0;
	logic [15:0] frame_count = '0;
	logic [14:0] frame_sum   = '0;
	logic [7:0]  ck_low      = '0;

	checksummed_packet_deframer #(
		.MAX_PAYLOAD(MAX_LEN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.value         (value),
		.status        (status),
		.payload_length(payload_length)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic result_t done_item(input status_t st, input logic [15:0] len);
		result_t r;
		r = '0;
		r.kind = KIND_DONE;
		r.status = st;
		r.payload_length = len;
		return r;
	endfunction

	function automatic result_t type_item(input logic [7:0] v);
		result_t r;
		r = '0;
		r.kind = KIND_TYPE;
		r.value = v;
		return r;
	endfunction

	function automatic bit deframe_step(input logic [7:0] b, output result_t r);
		logic [15:0] ck;
		r = '0;
		case (frame_phase)
			PH_HUNT0: begin
				if (b == START_A)
					frame_phase = PH_HUNT1;
				return 1'b0;
			end
			PH_HUNT1: begin
				if (b == START_B) begin
					frame_phase = PH_LEN_LO;
					return 1'b0;
				end
				r = done_item(ST_BAD_START, 16'd0);
				frame_phase = (b == START_A) ? PH_HUNT1 : PH_HUNT0;
				return 1'b1;
			end
			PH_LEN_LO: begin
				frame_len = {8'h00, b};
				frame_phase = PH_LEN_HI;
				return 1'b0;
			end
			PH_LEN_HI: begin
				frame_len = {b, frame_len[7:0]};
				if (frame_len == 16'd0 || frame_len > 16'(MAX_LEN)) begin
					r = done_item(ST_BAD_LENGTH, frame_len);
					frame_phase = PH_HUNT0;
					return 1'b1;
				end
				frame_count = '0;
				frame_sum = '0;
				frame_phase = PH_PAYLOAD;
				return 1'b0;
			end
			PH_PAYLOAD: begin
				r = type_item(b);
				if (frame_count != 16'd0)
					r.kind = KIND_DATA;
				frame_sum = frame_sum + 15'(b);
				frame_count = frame_count + 16'd1;
				if (frame_count >= frame_len)
					frame_phase = PH_CK_LO;
				return 1'b1;
			end
			PH_CK_LO: begin
				ck_low = b;
				frame_phase = PH_CK_HI;
				return 1'b0;
			end
			PH_CK_HI: begin
				ck = {b, ck_low};
				if (ck != {1'b0, frame_sum}) begin
					r = done_item(ST_BAD_CHECKSUM, frame_len);
					frame_phase = PH_HUNT0;
					return 1'b1;
				end
				frame_phase = PH_END0;
				return 1'b0;
			end
			PH_END0: begin
				if (b != END_A) begin
					r = done_item(ST_BAD_END, frame_len);
					frame_phase = PH_HUNT0;
					return 1'b1;
				end
				frame_phase = PH_END1;
				return 1'b0;
			end
			PH_END1: begin
				r = done_item((b != END_B) ? ST_BAD_END : ST_OK, frame_len);
				frame_phase = PH_HUNT0;
				return 1'b1;
			end
			default: begin
				frame_phase = PH_HUNT0;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic send_byte(input tx_step_t s);
		while (!(bytes_sent >= SRC_CALM_FIRST && bytes_sent < SRC_CALM_LAST)
		       && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		offered_steps.push_back(s);
		in_valid <= 1'b1;
		rx_byte <= s.rx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_raw(input logic [7:0] b);
		tx_step_t s;
		s.rx = b;
		s.typed = 1'b0;
		s.res = '0;
		send_byte(s);
	endtask

	task automatic send_random_frame(input logic [15:0] forced_len);
		int unsigned flaw;
		int unsigned pick;
		logic [15:0] len;
		logic [14:0] sum;
		logic [15:0] ck;
		logic [7:0]  b;
		logic [7:0]  e0;
		logic [7:0]  e1;
		flaw = (forced_len != 16'd0) ? 99 : $urandom_range(99);
		if ($urandom_range(7) == 0)
			repeat ($urandom_range(1, 5)) send_raw(8'($urandom_range(255)));
		send_raw(START_A);
		if (flaw < 5) begin
			send_raw(8'($urandom_range(255)));
			return;
		end
		send_raw(START_B);
		pick = $urandom_range(99);
		if (forced_len != 16'd0)
			len = forced_len;
		else if (flaw < 12)
			case ($urandom_range(3))
				0: len = 16'd0;
				1: len = 16'(MAX_LEN + 1);
				2: len = 16'hFFFF;
				default: len = 16'($urandom_range(MAX_LEN + 1, 16'hFFFF));
			endcase
		else if (pick < 70)
			len = 16'($urandom_range(1, 8));
		else if (pick < 95)
			len = 16'($urandom_range(9, 40));
		else
			len = 16'($urandom_range(41, 120));
		send_raw(len[7:0]);
		send_raw(len[15:8]);
		if (flaw < 12)
			return;
		sum = '0;
		for (int i = 0; i < int'(len); i++) begin
			b = (forced_len != 16'd0) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(255));
			sum = sum + 15'(b);
			send_raw(b);
		end
		ck = {1'b0, sum};
		if (flaw < 20)
			ck = ($urandom_range(1) != 0) ? (ck | 16'h8000)
			                              : (ck ^ 16'($urandom_range(1, 16'hFFFF)));
		send_raw(ck[7:0]);
		send_raw(ck[15:8]);
		e0 = END_A;
		e1 = END_B;
		if (flaw < 28) begin
			if ($urandom_range(1) != 0)
				e0 = END_A ^ 8'($urandom_range(1, 255));
			else
				e1 = END_B ^ 8'($urandom_range(1, 255));
		end
		send_raw(e0);
		send_raw(e1);
	endtask

	always @(posedge clk) begin : scoreboard
		tx_step_t note;
		result_t  r;
		result_t  e;
		bit       got;
		if (arst_n && in_valid && !in_stall) begin
			note = offered_steps.pop_front();
			got = deframe_step(rx_byte, r);
			if (note.typed)
				pending_results.push_back(note.res);
			else if (got)
				pending_results.push_back(r);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d value %02h status %0d",
				                          kind, value, status));
			end else begin
				e = pending_results.pop_front();
				if (kind !== e.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, e.kind));
				if (value !== e.value)
					report_mismatch($sformatf("value %02h, expected %02h", value, e.value));
				if (status !== e.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, e.status));
				if (payload_length !== e.payload_length)
					report_mismatch($sformatf("payload_length %0d, expected %0d",
					                          payload_length, e.payload_length));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("tb_checksummed_packet_deframer NOT OK");
				$finish;
			end
		end
	end

	initial begin : sink
		int unsigned cycle;
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle >= HOLD_FIRST && cycle < HOLD_FIRST + HOLD_CYCLES)
				out_stall <= 1'b1;
			else if (cycle >= SINK_CALM_FIRST && cycle < SINK_CALM_LAST)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	initial begin : stimulus
		bit max_sent;
		max_sent = 1'b0;
		directed = '{
			'{8'hFF,   1'b0, '0},
			'{START_A, 1'b0, '0},
			'{START_A, 1'b1, done_item(ST_BAD_START, 16'd0)},
			'{8'h55,   1'b1, done_item(ST_BAD_START, 16'd0)},
			'{START_A, 1'b0, '0},
			'{START_B, 1'b0, '0},
			'{8'h00,   1'b0, '0},
			'{8'h00,   1'b1, done_item(ST_BAD_LENGTH, 16'd0)},
			'{START_A, 1'b0, '0},
			'{START_B, 1'b0, '0},
			'{8'h01,   1'b0, '0},
			'{8'h00,   1'b0, '0},
			'{8'hFF,   1'b1, type_item(8'hFF)},
			'{8'hFF,   1'b0, '0},
			'{8'h80,   1'b1, done_item(ST_BAD_CHECKSUM, 16'd1)},
			'{START_A, 1'b0, '0},
			'{START_B, 1'b0, '0},
			'{8'h01,   1'b0, '0},
			'{8'h00,   1'b0, '0},
			'{8'h00,   1'b1, type_item(8'h00)},
			'{8'h00,   1'b0, '0},
			'{8'h00,   1'b0, '0},
			'{END_A,   1'b0, '0},
			'{8'hB1,   1'b1, done_item(ST_BAD_END, 16'd1)},
			'{START_A, 1'b0, '0},
			'{START_B, 1'b0, '0},
			'{8'h01,   1'b0, '0},
			'{8'h00,   1'b0, '0},
			'{8'h7F,   1'b1, type_item(8'h7F)},
			'{8'h7F,   1'b0, '0},
			'{8'h00,   1'b0, '0},
			'{END_A,   1'b0, '0},
			'{END_B,   1'b1, done_item(ST_OK, 16'd1)}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_byte(directed[i]);
		while (bytes_sent < N_DIRECTED + RANDOM_BYTES) begin
			if (!max_sent && bytes_sent > 400) begin
				max_sent = 1'b1;
				send_random_frame(16'(MAX_LEN));
			end else begin
				send_random_frame(16'd0);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_checksummed_packet_deframer OK");
		else
			$display("tb_checksummed_packet_deframer NOT OK");
		$finish;
	end

endmodule
